// ----- sv/gal_pkg.sv -----
package gal_pkg;

   // field widths of the channels
   localparam int OPCODE_W = 2;
   localparam int CODE_W   = 8;
   localparam int GLYPH_W  = 12;
   localparam int POS_W    = 18;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int HEIGHT_W = 12;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PLACE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PLACED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

   // sequencer states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_EMIT
   } fsm_type;

   // lookup token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic [CODE_W-1:0]  code;
      logic               hit;
      logic [GLYPH_W-1:0] width;
      logic [POS_W-1:0]   offset;
   } probe_type;

   // saturating add of a glyph width to an x position
   function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] a, logic [GLYPH_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + (POS_W+1)'(b);
      return s[POS_W] ? POS_MAX : s[POS_W-1:0];
   endfunction

endpackage

// ----- sv/gal_if.sv -----
interface gal_req_if;
   import gal_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CODE_W-1:0]   char_code;
   logic [GLYPH_W-1:0]  glyph_width;

   modport source (output valid, opcode, char_code, glyph_width, input ready);
   modport sink (input valid, opcode, char_code, glyph_width, output ready);
endinterface

interface gal_rsp_if;
   import gal_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [POS_W-1:0]    src_left;
   logic [POS_W-1:0]    src_right;
   logic [POS_W-1:0]    dest_left;
   logic [POS_W-1:0]    dest_right;
   logic [HEIGHT_W-1:0] top_y;
   logic [POS_W-1:0]    total_width;

   modport source (output valid, status, slot_index, src_left, src_right, dest_left,
                   dest_right, top_y, total_width, input ready);
   modport sink (input valid, status, slot_index, src_left, src_right, dest_left,
                 dest_right, top_y, total_width, output ready);
endinterface

// ----- sv/gal_cell.sv -----
module gal_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [gal_pkg::CODE_W-1:0]  wr_code,
   input  logic [gal_pkg::GLYPH_W-1:0] wr_width,
   input  logic [gal_pkg::POS_W-1:0]   wr_offset,
   input  logic                        live,
   input  gal_pkg::probe_type          up_probe,
   output gal_pkg::probe_type          dn_probe
);
   import gal_pkg::*;

   logic [CODE_W-1:0]  code_ff;
   logic [GLYPH_W-1:0] width_ff;
   logic [POS_W-1:0]   offset_ff;
   probe_type          probe_ff;
   probe_type          probe_in;
   logic               match;

   // glyph entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_ff   <= wr_code;
         width_ff  <= wr_width;
         offset_ff <= wr_offset;
      end
   end

   // first live entry with the same code claims the token
   always_comb begin
      match    = up_probe.active && !up_probe.hit && live && (code_ff == up_probe.code);
      probe_in = up_probe;
      if (match) begin
         probe_in.hit    = 1'b1;
         probe_in.width  = width_ff;
         probe_in.offset = offset_ff;
      end
   end

   // hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign dn_probe = probe_ff;

endmodule

// ----- sv/glyph_atlas_layout_core.sv -----
// channel   | dir | handshake    | beat
// ----------+-----+--------------+--------------------------------------------
// req_bus   | in  | valid/ready  | opcode, char_code, glyph_width
// rsp_bus   | out | valid/ready  | status, slot_index, src/dest spans, top_y,
//           |     |              | total_width
// csr_*     | in  | write enable | label_height
//
// load, begin and ignored beats are finished in the idle state; a place beat
// sends a token down the row of table cells, one cell per cycle, then the
// find is held in a register and emitted once the output register has space.
// one item is in flight at a time; the next beat is taken once the output
// register is empty or is being drained.
// reset is synchronous: table empty, pen, slot count and label height zero.
// a stalled result holds in the output register until rsp_bus.ready.
module glyph_atlas_layout_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_SLOTS   = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   gal_req_if.sink                      req_bus,
   gal_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [gal_pkg::HEIGHT_W-1:0] csr_wr_data
);
   import gal_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SCNT_W = $clog2(MAX_SLOTS + 1);

   // control and context registers
   fsm_type             state_ff, state_in;
   logic [HEIGHT_W-1:0] label_height_ff;
   logic [CNT_W-1:0]    entry_count_ff, entry_count_in;
   logic [POS_W-1:0]    atlas_end_ff, atlas_end_in;
   logic [POS_W-1:0]    pen_x_ff, pen_x_in;
   logic [SCNT_W-1:0]   slot_count_ff, slot_count_in;
   probe_type           hold_ff, hold_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_index_ff, slot_index_in;
   logic [POS_W-1:0]    src_left_ff, src_left_in;
   logic [POS_W-1:0]    src_right_ff, src_right_in;
   logic [POS_W-1:0]    dest_left_ff, dest_left_in;
   logic [POS_W-1:0]    dest_right_ff, dest_right_in;
   logic [HEIGHT_W-1:0] top_y_ff, top_y_in;
   logic [POS_W-1:0]    total_width_ff, total_width_in;

   logic                req_fire;
   logic                out_space;
   logic                out_load;
   logic                load_go;
   logic                place_go;
   logic [POS_W-1:0]    pen_next;
   probe_type           probe [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] probe_act;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_space = !rsp_valid_ff || rsp_bus.ready;
   assign pen_next  = sat_add(pen_x_ff, hold_ff.width);

   // token injected at the head of the row
   always_comb begin
      probe[0]        = '0;
      probe[0].active = place_go;
      probe[0].code   = req_bus.char_code;
   end

   // row of table cells
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      gal_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (load_go && (entry_count_ff == CNT_W'(k))),
         .wr_code   (req_bus.char_code),
         .wr_width  (req_bus.glyph_width),
         .wr_offset (atlas_end_ff),
         .live      (CNT_W'(k) < entry_count_ff),
         .up_probe  (probe[k]),
         .dn_probe  (probe[k+1])
      );
      assign probe_act[k] = probe[k+1].active;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (place_go) state_in = FSM_WALK;
         end
         FSM_WALK: begin
            if (probe[TABLE_DEPTH].active) state_in = FSM_EMIT;
         end
         FSM_EMIT: begin
            if (out_space) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      req_bus.ready  = 1'b0;
      load_go        = 1'b0;
      place_go       = 1'b0;
      out_load       = 1'b0;
      entry_count_in = entry_count_ff;
      atlas_end_in   = atlas_end_ff;
      pen_x_in       = pen_x_ff;
      slot_count_in  = slot_count_ff;
      hold_in        = hold_ff;
      status_in      = ST_PLACED;
      slot_index_in  = '0;
      src_left_in    = '0;
      src_right_in   = '0;
      dest_left_in   = '0;
      dest_right_in  = '0;
      top_y_in       = '0;
      total_width_in = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_bus.ready = out_space;
            if (req_fire) begin
               unique case (req_bus.opcode)
                  OP_LOAD: begin
                     out_load = 1'b1;
                     if (entry_count_ff == CNT_W'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in      = ST_STORED;
                        load_go        = 1'b1;
                        entry_count_in = entry_count_ff + CNT_W'(1);
                        atlas_end_in   = sat_add(atlas_end_ff, req_bus.glyph_width);
                     end
                  end
                  OP_BEGIN: begin
                     out_load      = 1'b1;
                     status_in     = ST_RESTARTED;
                     pen_x_in      = '0;
                     slot_count_in = '0;
                  end
                  OP_PLACE: begin
                     if (slot_count_ff == SCNT_W'(MAX_SLOTS)) begin
                        out_load  = 1'b1;
                        status_in = ST_TOO_LONG;
                     end else begin
                        place_go = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FSM_WALK: begin
            if (probe[TABLE_DEPTH].active) hold_in = probe[TABLE_DEPTH];
         end
         FSM_EMIT: begin
            if (out_space) begin
               out_load      = 1'b1;
               slot_index_in = SLOT_W'(slot_count_ff);
               slot_count_in = slot_count_ff + SCNT_W'(1);
               if (hold_ff.hit) begin
                  status_in      = ST_PLACED;
                  src_left_in    = hold_ff.offset;
                  src_right_in   = sat_add(hold_ff.offset, hold_ff.width);
                  dest_left_in   = pen_x_ff;
                  dest_right_in  = pen_next;
                  top_y_in       = label_height_ff;
                  total_width_in = pen_next;
                  pen_x_in       = pen_next;
               end else begin
                  status_in      = ST_NOT_FOUND;
                  total_width_in = pen_x_ff;
               end
            end
         end
         default: ;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         label_height_ff <= '0;
         entry_count_ff  <= '0;
         atlas_end_ff    <= '0;
         pen_x_ff        <= '0;
         slot_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         atlas_end_ff   <= atlas_end_in;
         pen_x_ff       <= pen_x_in;
         slot_count_ff  <= slot_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) label_height_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (out_load) begin
         status_ff      <= status_in;
         slot_index_ff  <= slot_index_in;
         src_left_ff    <= src_left_in;
         src_right_ff   <= src_right_in;
         dest_left_ff   <= dest_left_in;
         dest_right_ff  <= dest_right_in;
         top_y_ff       <= top_y_in;
         total_width_ff <= total_width_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.slot_index  = slot_index_ff;
   assign rsp_bus.src_left    = src_left_ff;
   assign rsp_bus.src_right   = src_right_ff;
   assign rsp_bus.dest_left   = dest_left_ff;
   assign rsp_bus.dest_right  = dest_right_ff;
   assign rsp_bus.top_y       = top_y_ff;
   assign rsp_bus.total_width = total_width_ff;

   // at most one lookup token travels the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(probe_act) <= 1)
      else $error("more than one lookup token in the cell row");

   // a token only leaves the row while the sequencer waits for it
   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      probe[TABLE_DEPTH].active |-> (state_ff == FSM_WALK))
      else $error("lookup token left the row outside the walk state");

   // table and slot counters stay within their limits
   a_counts: assert property (@(posedge clock) disable iff (reset)
      (entry_count_ff <= CNT_W'(TABLE_DEPTH)) && (slot_count_ff <= SCNT_W'(MAX_SLOTS)))
      else $error("entry or slot count beyond its limit");

   // a finished lookup always lands in the output register
   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_EMIT) && out_space) |=> rsp_valid_ff)
      else $error("place result lost on emit");

endmodule

// ----- verif/tb_glyph_atlas_layout_core.sv -----
`timescale 1ns / 100ps

module tb_glyph_atlas_layout_core;
   import gal_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int MAX_SLOTS     = 64;
   localparam int ITEM_TARGET   = 1150;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 2000;

   // opcode 3 has no meaning; the block drops it without a result
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [POS_W-1:0]    src_l;
      logic [POS_W-1:0]    src_r;
      logic [POS_W-1:0]    dst_l;
      logic [POS_W-1:0]    dst_r;
      logic [HEIGHT_W-1:0] top;
      logic [POS_W-1:0]    total;
   } layout_beat_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [CODE_W-1:0]   code;
      logic [GLYPH_W-1:0]  wd;
      bit                  fixed;
      layout_beat_type     beat;
   } script_row_type;

   logic clock;
   logic reset;
   logic                csr_wr_en;
   logic [HEIGHT_W-1:0] csr_wr_data;

   gal_req_if req_bus ();
   gal_rsp_if rsp_bus ();

   glyph_atlas_layout_core #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_SLOTS   (MAX_SLOTS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // layout state mirrored from the block
   logic [CODE_W-1:0]   glyph_code [TABLE_DEPTH];
   logic [GLYPH_W-1:0]  glyph_wd   [TABLE_DEPTH];
   logic [POS_W-1:0]    glyph_off  [TABLE_DEPTH];
   int                  glyph_count;
   logic [POS_W-1:0]    atlas_fill;
   logic [POS_W-1:0]    pen_pos;
   int                  slot_used;
   logic [HEIGHT_W-1:0] label_h;

   layout_beat_type pending_layouts [$];
   script_row_type  script_rows [$];

   int items_sent;
   int results_seen;
   int mismatch_count;
   int status_seen [6];
   int label_writes;
   int req_gap_max;
   int rsp_stall_max;
   int hold_req;
   int stall_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [POS_W-1:0] clip_sum(logic [POS_W-1:0] a, logic [GLYPH_W-1:0] b);
      int unsigned s;
      s = 32'(a) + 32'(b);
      return (s > POS_MAX) ? POS_MAX : s[POS_W-1:0];
   endfunction

   function automatic layout_beat_type only_status(logic [STATUS_W-1:0] st);
      layout_beat_type b;
      b = '0;
      b.status = st;
      return b;
   endfunction

   // glyph widths: mostly narrow, now and then up to the field maximum
   function automatic logic [GLYPH_W-1:0] pick_width();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return {GLYPH_W{1'b1}};
      if (sel == 1) return GLYPH_W'($urandom_range(0, 4095));
      return GLYPH_W'($urandom_range(0, 64));
   endfunction

   // code to load: sometimes a duplicate of a loaded glyph, so the first match must win
   function automatic logic [CODE_W-1:0] load_code();
      if (glyph_count > 0 && $urandom_range(0, 3) == 0)
         return glyph_code[$urandom_range(0, glyph_count - 1)];
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // code to place: mostly one that is in the table
   function automatic logic [CODE_W-1:0] place_code();
      if (glyph_count > 0 && $urandom_range(0, 19) > 2)
         return glyph_code[$urandom_range(0, glyph_count - 1)];
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // layout predictor: one request beat in, at most one result out
   task automatic advance_layout(input logic [OPCODE_W-1:0] op, input logic [CODE_W-1:0] code,
                                 input logic [GLYPH_W-1:0] wd, output bit produced,
                                 output layout_beat_type beat);
      int hit;
      beat = '0;
      hit = -1;
      produced = (op != OP_UNUSED);
      case (op)
         OP_LOAD: begin
            if (glyph_count >= TABLE_DEPTH) begin
               beat.status = ST_FULL;
            end else begin
               glyph_code[glyph_count] = code;
               glyph_wd[glyph_count] = wd;
               glyph_off[glyph_count] = atlas_fill;
               glyph_count++;
               atlas_fill = clip_sum(atlas_fill, wd);
               beat.status = ST_STORED;
            end
         end
         OP_BEGIN: begin
            pen_pos = '0;
            slot_used = 0;
            beat.status = ST_RESTARTED;
         end
         OP_PLACE: begin
            if (slot_used >= MAX_SLOTS) begin
               beat.status = ST_TOO_LONG;
            end else begin
               beat.slot = SLOT_W'(slot_used);
               for (int i = glyph_count - 1; i >= 0; i--)
                  if (glyph_code[i] == code) hit = i;
               if (hit < 0) begin
                  beat.status = ST_NOT_FOUND;
                  beat.total = pen_pos;
               end else begin
                  beat.status = ST_PLACED;
                  beat.src_l = glyph_off[hit];
                  beat.src_r = clip_sum(glyph_off[hit], glyph_wd[hit]);
                  beat.dst_l = pen_pos;
                  beat.dst_r = clip_sum(pen_pos, glyph_wd[hit]);
                  beat.top = label_h;
                  pen_pos = beat.dst_r;
                  beat.total = pen_pos;
               end
               slot_used++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("tb_glyph_atlas_layout_core: mismatch on result %0d: %s", results_seen, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // offer one request beat; called and left at a falling edge
   task automatic offer_beat(input logic [OPCODE_W-1:0] op, input logic [CODE_W-1:0] code,
                             input logic [GLYPH_W-1:0] wd, input bit fixed = 1'b0,
                             input layout_beat_type fixed_beat = '0);
      int gap;
      bit produced;
      layout_beat_type want;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         req_bus.opcode = OPCODE_W'($urandom_range(0, 3));
         req_bus.char_code = CODE_W'($urandom_range(0, 255));
         req_bus.glyph_width = GLYPH_W'($urandom_range(0, 4095));
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = op;
      req_bus.char_code = code;
      req_bus.glyph_width = wd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_layout(op, code, wd, produced, want);
      if (produced) pending_layouts = {pending_layouts, (fixed ? fixed_beat : want)};
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // stop offering, wait out every result and any beat still being worked on
   task automatic drain_block();
      req_bus.valid = 1'b0;
      while (pending_layouts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_label(logic [HEIGHT_W-1:0] h);
      csr_wr_en = 1'b1;
      csr_wr_data = h;
      @(negedge clock);
      csr_wr_en = 1'b0;
      label_h = h;
      label_writes++;
   endtask

   task automatic add_row(logic [OPCODE_W-1:0] op, logic [CODE_W-1:0] code,
                          logic [GLYPH_W-1:0] wd, bit fixed = 1'b0,
                          layout_beat_type beat = '0);
      script_row_type r;
      r.op = op;
      r.code = code;
      r.wd = wd;
      r.fixed = fixed;
      r.beat = beat;
      script_rows = {script_rows, r};
   endtask

   // result pacing: ready low for the drawn stall, or for a long hold when asked
   initial begin : rsp_pacer
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // result checker: each accepted beat against the oldest expectation
   always @(posedge clock) begin : rsp_checker
      layout_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_layouts.size() == 0) begin
            flag_mismatch($sformatf("result with nothing expected, status %0d", rsp_bus.status));
         end else begin
            want = pending_layouts.pop_front();
            check_field("status", 32'(rsp_bus.status), 32'(want.status));
            check_field("slot_index", 32'(rsp_bus.slot_index), 32'(want.slot));
            check_field("src_left", 32'(rsp_bus.src_left), 32'(want.src_l));
            check_field("src_right", 32'(rsp_bus.src_right), 32'(want.src_r));
            check_field("dest_left", 32'(rsp_bus.dest_left), 32'(want.dst_l));
            check_field("dest_right", 32'(rsp_bus.dest_right), 32'(want.dst_r));
            check_field("top_y", 32'(rsp_bus.top_y), 32'(want.top));
            check_field("total_width", 32'(rsp_bus.total_width), 32'(want.total));
         end
         if (rsp_bus.status <= ST_TOO_LONG) status_seen[rsp_bus.status]++;
         results_seen++;
         stall_left = $urandom_range(0, rsp_stall_max);
      end
   end

   // watchdog: cycles with no beat accepted on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_glyph_atlas_layout_core: no beat accepted for %0d cycles", quiet);
      $display("tb_glyph_atlas_layout_core: done, errors");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int n_loads;
      int str_len;
      int pick;
      logic [HEIGHT_W-1:0] h;

      // known values on every input from the start
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_LOAD;
      req_bus.char_code = '0;
      req_bus.glyph_width = '0;
      glyph_count = 0;
      atlas_fill = '0;
      pen_pos = '0;
      slot_used = 0;
      label_h = '0;
      items_sent = 0;
      results_seen = 0;
      mismatch_count = 0;
      label_writes = 0;
      hold_req = 0;
      stall_left = 0;
      req_gap_max = 8;
      rsp_stall_max = 8;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, duplicates, ignored opcode
      add_row(OP_PLACE, 8'h41, 12'd0, 1'b1, only_status(ST_NOT_FOUND));
      add_row(OP_UNUSED, 8'hFF, 12'hFFF);
      add_row(OP_BEGIN, 8'h00, 12'd0, 1'b1, only_status(ST_RESTARTED));
      add_row(OP_LOAD, 8'h00, 12'd0, 1'b1, only_status(ST_STORED));
      add_row(OP_LOAD, 8'hFF, 12'hFFF, 1'b1, only_status(ST_STORED));
      add_row(OP_LOAD, 8'h41, 12'd10, 1'b1, only_status(ST_STORED));
      add_row(OP_LOAD, 8'h41, 12'd20, 1'b1, only_status(ST_STORED));
      add_row(OP_PLACE, 8'h41, 12'hFFF);
      add_row(OP_PLACE, 8'hFF, 12'd0);
      add_row(OP_PLACE, 8'h00, 12'd5);
      add_row(OP_PLACE, 8'h7E, 12'd0);
      add_row(OP_PLACE, 8'h41, 12'd0);
      add_row(OP_BEGIN, 8'hFF, 12'hFFF, 1'b1, only_status(ST_RESTARTED));
      add_row(OP_PLACE, 8'h00, 12'hFFF, 1'b1, only_status(ST_PLACED));
      add_row(OP_UNUSED, 8'h00, 12'd0);
      add_row(OP_LOAD, 8'h80, 12'hFFF, 1'b1, only_status(ST_STORED));
      add_row(OP_PLACE, 8'h80, 12'd0);
      add_row(OP_PLACE, 8'hFF, 12'd0);
      add_row(OP_PLACE, 8'h01, 12'd0);
      foreach (script_rows[i])
         offer_beat(script_rows[i].op, script_rows[i].code, script_rows[i].wd,
                    script_rows[i].fixed, script_rows[i].beat);

      // random phases: a few loads, usually a begin, then a string of places with some noise
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_block();
         case (phase)
            0: h = {HEIGHT_W{1'b1}};
            1: h = '0;
            default: h = HEIGHT_W'($urandom_range(0, 4095));
         endcase
         write_label(h);
         if (phase % 5 == 3) begin
            req_gap_max = 0;
            rsp_stall_max = 0;
         end else begin
            req_gap_max = $urandom_range(0, 1) * 8;
            rsp_stall_max = $urandom_range(0, 1) * 8;
         end
         // long hold on the result side while requests keep coming
         if (phase == 2) hold_req = LONG_HOLD;

         n_loads = (glyph_count < TABLE_DEPTH) ? $urandom_range(2, 10) : $urandom_range(0, 1);
         repeat (n_loads) offer_beat(OP_LOAD, load_code(), pick_width());
         if ($urandom_range(0, 7) != 0)
            offer_beat(OP_BEGIN, CODE_W'($urandom_range(0, 255)),
                       GLYPH_W'($urandom_range(0, 4095)));

         // some strings run past the slot limit
         str_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
         repeat (str_len) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
               offer_beat(OP_UNUSED, CODE_W'($urandom_range(0, 255)),
                          GLYPH_W'($urandom_range(0, 4095)));
            else if (pick == 1)
               offer_beat(OP_LOAD, load_code(), pick_width());
            else if (pick == 2)
               offer_beat(OP_BEGIN, CODE_W'($urandom_range(0, 255)),
                          GLYPH_W'($urandom_range(0, 4095)));
            else
               offer_beat(OP_PLACE, place_code(), GLYPH_W'($urandom_range(0, 4095)));
         end
         phase++;
      end
      drain_block();

      $display({"tb_glyph_atlas_layout_core: %0d beats in %0d phases, %0d results: ",
                "%0d placed, %0d not found, %0d stored"},
               items_sent, phase, results_seen, status_seen[ST_PLACED],
               status_seen[ST_NOT_FOUND], status_seen[ST_STORED]);
      $display({"tb_glyph_atlas_layout_core: %0d table full, %0d restarts, %0d too long, ",
                "%0d label heights, %0d mismatches"},
               status_seen[ST_FULL], status_seen[ST_RESTARTED], status_seen[ST_TOO_LONG],
               label_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_glyph_atlas_layout_core: done, clean");
      else
         $display("tb_glyph_atlas_layout_core: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
sv/gal_pkg.sv
sv/gal_if.sv
sv/gal_cell.sv
sv/glyph_atlas_layout_core.sv
verif/tb_glyph_atlas_layout_core.sv
